>>> hdl/ipv4fmt_pkg.sv
// Shared types and constants for the IPv4 dotted decimal formatter.
package ipv4fmt_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned OCTET_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

    // Index of the final octet (bits 7:0) in printing order.
    localparam logic [1:0] LAST_OCTET = 2'd3;

    // Which character the datapath puts into the output register.
    typedef enum logic [1:0] {
        SEL_HUND,
        SEL_TENS,
        SEL_ONES,
        SEL_DOT
    } t_char_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;   // take the incoming address
        logic      emit;   // write one character into the output register
        logic      shift;  // move the next octet to the top
        logic      last;   // the emitted character closes the text
        t_char_sel sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a character this cycle
        logic cur_ge100; // current octet has three digits
        logic cur_ge10;  // current octet has at least two digits
        logic in_ge100;  // first octet of the incoming address, same meaning
        logic in_ge10;
    } t_dp_stat;

endpackage

>>> hdl/ipv4fmt_ctrl.sv
// Controller that walks the digits and dots of one address.
module ipv4fmt_ctrl
    import ipv4fmt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wr_en,
    input  logic     i_cfg_wr_data,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HUND,
        ST_TENS,
        ST_ONES,
        ST_DOT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_octet, n_octet;
    logic       r_padded;

    // First digit state of an octet, from its size and the mode.
    function automatic t_state first_digit(input logic padded, input logic ge100,
                                           input logic ge10);
        t_state s;
        if (padded || ge100) begin
            s = ST_HUND;
        end else if (ge10) begin
            s = ST_TENS;
        end else begin
            s = ST_ONES;
        end
        return s;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_octet    = r_octet;
        o_cmd      = '{load: 1'b0, emit: 1'b0, shift: 1'b0, last: 1'b0, sel: SEL_ONES};
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_octet    = 2'd0;
                    n_state    = first_digit(r_padded, i_stat.in_ge100, i_stat.in_ge10);
                end
            end
            ST_HUND: begin
                o_cmd.sel = SEL_HUND;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_TENS;
                end
            end
            ST_TENS: begin
                o_cmd.sel = SEL_TENS;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_ONES;
                end
            end
            ST_ONES: begin
                o_cmd.sel = SEL_ONES;
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.shift = 1'b1;
                    if (r_octet == LAST_OCTET) begin
                        o_cmd.last = 1'b1;
                        o_in_ready = 1'b1;
                        if (i_in_valid) begin
                            o_cmd.load = 1'b1;
                            n_octet    = 2'd0;
                            n_state    = first_digit(r_padded, i_stat.in_ge100,
                                                     i_stat.in_ge10);
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_octet = r_octet + 2'd1;
                        n_state = ST_DOT;
                    end
                end
            end
            ST_DOT: begin
                o_cmd.sel = SEL_DOT;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = first_digit(r_padded, i_stat.cur_ge100, i_stat.cur_ge10);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_octet  <= 2'd0;
            r_padded <= 1'b0;
        end else begin
            r_state <= n_state;
            r_octet <= n_octet;
            if (i_cfg_wr_en) begin
                r_padded <= i_cfg_wr_data;
            end
        end
    end

endmodule

>>> hdl/ipv4fmt_dp.sv
// Datapath: address register, octet to decimal digits, output register.
module ipv4fmt_dp
    import ipv4fmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    logic [ADDR_W-1:0]  r_addr;
    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [OCTET_W-1:0] octet;
    logic [1:0]         hund;
    logic [6:0]         rem100;
    logic [14:0]        tens_prod;
    logic [3:0]         tens;
    logic [3:0]         ones;
    logic [6:0]         tens_x10;
    logic [CHAR_W-1:0]  n_char;

    assign octet = r_addr[ADDR_W-1 -: OCTET_W];

    // Hundreds by compare, tens by multiplying with 205/2048 (exact below 100).
    always_comb begin
        if (octet >= 8'd200) begin
            hund   = 2'd2;
            rem100 = 7'(octet - 8'd200);
        end else if (octet >= 8'd100) begin
            hund   = 2'd1;
            rem100 = 7'(octet - 8'd100);
        end else begin
            hund   = 2'd0;
            rem100 = octet[6:0];
        end
        tens_prod = 15'(rem100) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = {tens[3:0], 3'b000} - {2'b00, tens[3:0], 1'b0} + {tens[3:0], 1'b0} * 7'd2;
        ones      = 4'(rem100 - tens_x10);
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_HUND: n_char = CHAR_ZERO + CHAR_W'(hund);
            SEL_TENS: n_char = CHAR_ZERO + CHAR_W'(tens);
            SEL_ONES: n_char = CHAR_ZERO + CHAR_W'(ones);
            default:  n_char = CHAR_DOT;
        endcase
    end

    assign o_stat.out_free  = !r_valid || i_ready;
    assign o_stat.cur_ge100 = octet >= 8'd100;
    assign o_stat.cur_ge10  = octet >= 8'd10;
    assign o_stat.in_ge100  = i_addr[ADDR_W-1 -: OCTET_W] >= 8'd100;
    assign o_stat.in_ge10   = i_addr[ADDR_W-1 -: OCTET_W] >= 8'd10;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_addr;
        end else if (i_cmd.shift) begin
            r_addr <= {r_addr[ADDR_W-OCTET_W-1:0], {OCTET_W{1'b0}}};
        end
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

>>> hdl/ipv4_dotted_decimal_formatter.sv
// Top level of the IPv4 dotted decimal formatter.
//
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid tready tdata[31:0]      address, bits 31:24 printed first
//  m_axis    out        tvalid tready tdata[7:0] tlast ASCII character, tlast on final one
//  cfg       in         wr_en wr_data[0]               padded_mode (1 = three digits)
//
// Each request produces one character per cycle while the output is not
// stalled: 7 to 15 characters in normal mode and 15 in padded mode.
// The character sequencer sets this rate, since it emits one digit or dot
// per cycle and takes the next address in the cycle of the final character.
// Reset is synchronous and active low; it empties the output register and
// returns the mode to normal. A stall on m_axis holds the current character
// and pauses the sequencer, which then also holds off s_axis; an idle sequencer still takes a request.
module ipv4_dotted_decimal_formatter
    import ipv4fmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: bit 0 is padded_mode.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // Request side. tdata: [31:0] address.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,
    // Result side. tdata: [7:0] character.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The controller decides which character comes next and when to take a request.
    ipv4fmt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // The datapath holds the address, turns its top octet into digits and
    // keeps the registered output character.
    ipv4fmt_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_addr (i_s_axis_tdata),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_char (o_m_axis_tdata),
        .o_last (o_m_axis_tlast)
    );

endmodule

>>> hdl/ipv4fmt_checker.sv
// Port-level checks for the IPv4 dotted decimal formatter, with its bind.
module ipv4fmt_checker
    import ipv4fmt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // A stalled character stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled character changed");

    // Only digits and dots leave the block.
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata >= CHAR_ZERO && o_m_axis_tdata <= CHAR_NINE) ||
            o_m_axis_tdata == CHAR_DOT)
        else $error("character outside digits and dot");

    // The text always ends in a digit.
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata != CHAR_DOT)
        else $error("text ends in a dot");

    // Two dots never follow each other.
    a_no_double_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tdata == CHAR_DOT ##1
            o_m_axis_tvalid |-> o_m_axis_tdata != CHAR_DOT)
        else $error("two dots in a row");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind ipv4_dotted_decimal_formatter ipv4fmt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tlast (o_m_axis_tlast)
);

>>> verif/testbench.sv
// Self-checking testbench for the IPv4 dotted decimal formatter.
`timescale 1ns / 100ps

module testbench;
    import ipv4fmt_pkg::*;

    // Values of the one configuration bit.
    localparam logic MODE_NORMAL = 1'b0;
    localparam logic MODE_PADDED = 1'b1;

    // Patterns that the result side uses to hold off the block.
    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    // Generous bound on the whole run. The slowest correct run is about 400
    // addresses of 15 characters, each character held up by the heavy stall
    // pattern, plus the sender's random gaps.
    localparam int unsigned CYCLE_LIMIT = 600000;

    // One character of the printed text as it should leave the block.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_wr_en     = 1'b0;
    logic              i_cfg_wr_data   = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [ADDR_W-1:0] i_s_axis_tdata  = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [CHAR_W-1:0] o_m_axis_tdata;
    logic              o_m_axis_tlast;

    // Addresses waiting to be offered, and the characters still owed by the block.
    logic [ADDR_W-1:0] address_queue[$];
    text_char_t        owed_chars[$];

    // The predictor's own copy of the mode register.
    logic        padded_mode = MODE_NORMAL;

    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned normal_count   = 0;
    int unsigned padded_count   = 0;
    int unsigned checked_chars  = 0;
    int unsigned longest_text   = 0;
    int unsigned text_len       = 0;

    // Sender burst state and receiver stall state.
    int unsigned burst_left  = 1;
    int unsigned gap_left    = 0;
    int unsigned stall_style = STALL_NONE;
    int unsigned stall_hold  = 0;

    ipv4_dotted_decimal_formatter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Print one line per mismatch and keep count; the run carries on.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        $display("mismatch at cycle %0d: %s expected %0h got %0h",
                 cycle_count, what, want, got);
    endtask

    // Work out the text of one address under the given mode and queue its
    // characters. Each octet is split into hundreds, tens and ones. In normal
    // mode the leading digits are dropped while they are zero, so a zero octet
    // still prints its ones digit. The ones digit of the final octet is always
    // the closing character of the text.
    task automatic queue_dotted_text(input logic [ADDR_W-1:0] address,
                                     input logic padded);
        logic [OCTET_W-1:0] octet;
        int unsigned        hund;
        int unsigned        tens;
        int unsigned        ones;
        for (int k = 0; k < 4; k++) begin
            octet = address[8*(3-k) +: 8];
            hund  = octet / 100;
            tens  = (octet / 10) % 10;
            ones  = octet % 10;
            if (k != 0) begin
                owed_chars.push_back('{code: CHAR_DOT, last: 1'b0});
            end
            if (padded || octet >= 100) begin
                owed_chars.push_back('{code: CHAR_W'(CHAR_ZERO + hund), last: 1'b0});
            end
            if (padded || octet >= 10) begin
                owed_chars.push_back('{code: CHAR_W'(CHAR_ZERO + tens), last: 1'b0});
            end
            owed_chars.push_back('{code: CHAR_W'(CHAR_ZERO + ones), last: (k == 3)});
        end
    endtask

    // Random address whose octets are biased toward each digit count, so that
    // one, two and three digit octets all turn up often in every position.
    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] address;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 4))
                0:       address[8*k +: 8] = 8'($urandom_range(0, 9));
                1:       address[8*k +: 8] = 8'($urandom_range(10, 99));
                2:       address[8*k +: 8] = 8'($urandom_range(100, 255));
                3:       address[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
                default: address[8*k +: 8] = 8'($urandom);
            endcase
        end
        return address;
    endfunction

    // Write the mode register. Called only while the block is idle; the
    // predictor's copy follows at the edge that performs the write.
    task automatic write_mode(input logic mode);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        padded_mode    = mode;
    endtask

    // Hold back until every queued address has been taken and every owed
    // character has arrived, then let the sequencer settle.
    // The check runs at the falling edge, once the sender's updates from the
    // rising edge have settled, so a request that was just popped is seen.
    task automatic wait_for_drain();
        while (address_queue.size() != 0 || i_s_axis_tvalid || owed_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_directed();
        address_queue.push_back(32'h0000_0000);   // all octets zero
        address_queue.push_back(32'hFFFF_FFFF);   // all octets at the maximum
        address_queue.push_back(32'h0A63_6409);   // 10.99.100.9, digit count edges
        address_queue.push_back(32'h090A_6364);   // 9.10.99.100
        address_queue.push_back(32'hC7C8_FF00);   // 199.200.255.0
        address_queue.push_back(32'hC0A8_0001);   // a typical private address
        address_queue.push_back(32'h7F00_0001);   // loopback
        address_queue.push_back(32'h8000_0000);   // only the top bit set
        address_queue.push_back(32'h0000_0001);   // only the bottom bit set
        address_queue.push_back(32'h5555_5555);
        address_queue.push_back(32'hAAAA_AAAA);
        address_queue.push_back(32'h0102_0304);
    endtask

    // Request driver. Addresses go out in bursts of random length separated by
    // gaps of random length; a gap of zero gives long stretches at full rate.
    // A new request is only presented once the previous one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (address_queue.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= address_queue.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1, 2:    gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 40);
                    endcase
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side backpressure. The pattern is picked at random whenever its
    // hold runs out, among always ready, coin flips, a fixed one-in-three rhythm and a
    // heavy stall that lets a character through about one cycle in eight.
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_style = $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_hold  = $urandom_range(20, 120);
        end else begin
            stall_hold--;
        end
        case (stall_style)
            STALL_NONE:     i_m_axis_tready <= 1'b1;
            STALL_RANDOM:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: i_m_axis_tready <= (cycle_count % 3 == 0);
            default:        i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Monitor. Both sides are sampled at the rising edge, where the values seen
    // are those that the handshake is decided on. An accepted request queues
    // its whole text; an accepted character is checked against the oldest one.
    always @(posedge i_clk) begin
        text_char_t want;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            queue_dotted_text(i_s_axis_tdata, padded_mode);
            if (padded_mode == MODE_PADDED) begin
                padded_count++;
            end else begin
                normal_count++;
            end
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            text_len++;
            if (o_m_axis_tlast) begin
                if (text_len > longest_text) begin
                    longest_text = text_len;
                end
                text_len = 0;
            end
            if (owed_chars.size() == 0) begin
                report_mismatch("unexpected character", 32'h0, 32'(o_m_axis_tdata));
            end else begin
                want = owed_chars.pop_front();
                checked_chars++;
                if (o_m_axis_tdata !== want.code) begin
                    report_mismatch("character", 32'(want.code), 32'(o_m_axis_tdata));
                end
                if (o_m_axis_tlast !== want.last) begin
                    report_mismatch("tlast", 32'(want.last), 32'(o_m_axis_tlast));
                end
            end
        end
    end

    // Watchdog: a hung block or a lost character ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d characters outstanding",
                     cycle_count, owed_chars.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Sequence of the run. Reset once, then phases that each set the mode while
    // the block is idle and then stream addresses. Every phase ends with the
    // sender waiting until all owed characters have come back, which also puts
    // the block through full drains between bursts of work.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short directed pass in both modes: field extremes, every digit count
        // edge and zero octets in each position.
        write_mode(MODE_NORMAL);
        load_directed();
        wait_for_drain();

        write_mode(MODE_PADDED);
        load_directed();
        wait_for_drain();

        // Random traffic, with the mode toggled between phases.
        write_mode(MODE_NORMAL);
        repeat (140) address_queue.push_back(random_address());
        wait_for_drain();

        write_mode(MODE_PADDED);
        repeat (110) address_queue.push_back(random_address());
        wait_for_drain();

        write_mode(MODE_NORMAL);
        repeat (110) address_queue.push_back(random_address());
        wait_for_drain();

        repeat (20) @(posedge i_clk);
        if (owed_chars.size() != 0) begin
            report_mismatch("characters left over", 32'h0, 32'(owed_chars.size()));
        end

        $display("covered %0d addresses in normal mode and %0d in padded mode,",
                 normal_count, padded_count);
        $display("%0d characters checked, longest text %0d, stalls on both sides",
                 checked_chars, longest_text);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
